// ----- rtl/lst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_pkg
// Shared constants for the lazy segment tree: sizes, widths, operation codes.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int LEAVES  = 1024;
  localparam int LOG     = $clog2(LEAVES);     // tree height, T = 2**LOG leaves
  localparam int NODE_W  = LOG + 1;            // node index 1 .. 2T-1
  localparam int LVL_W   = $clog2(LOG + 1);    // level 0 .. LOG
  localparam int DATA_W  = 64;
  localparam int OP_W    = 2;
  localparam int RANGE_W = 11;
  localparam int IN_W    = 88;                 // 2+11+11+64, whole bytes

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

endpackage

// ----- rtl/lst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lst_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lst_ram #(
  parameter int ADDR_W = 11,
  parameter int WIDTH  = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lazy_segment_tree_range_add_sum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_segment_tree_range_add_sum
// Lazy segment tree over 1024 signed 64-bit elements: set, build, range add,
// range sum. One node RAM pair walked by a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata, low bit first)
// s_axis    in   operation[1:0], range_lo[12:2], range_hi[23:13], value[87:24]
// m_axis    out  sum[63:0]
//
// Build reads both children of every internal node and writes their sum;
// add/query walk the tree depth first over at most 4*log2(T) nodes, with
// a return step per finished node; the single read port of each node RAM
// sets the pace. After reset a clearing pass writes zero to all 2T node
// entries before the first item is taken.
// One item at a time; s_axis_tready is high only while idle. The result
// sits in an output register until the downstream transfer completes.
// ----------------------------------------------------------------------------
module lazy_segment_tree_range_add_sum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [lst_pkg::IN_W-1:0]   s_axis_tdata,   // operation, range_lo, range_hi, value
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [lst_pkg::DATA_W-1:0] m_axis_tdata    // sum
);
  import lst_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SET  = 4'd2;
  localparam logic [3:0] S_BR0  = 4'd3;
  localparam logic [3:0] S_BR1  = 4'd4;
  localparam logic [3:0] S_BW   = 4'd5;
  localparam logic [3:0] S_VRD  = 4'd6;
  localparam logic [3:0] S_VEX  = 4'd7;
  localparam logic [3:0] S_C0W  = 4'd8;
  localparam logic [3:0] S_C1W  = 4'd9;
  localparam logic [3:0] S_RET  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [NODE_W-1:0] T_NODE = NODE_W'(1) << LOG;

  logic [3:0]         state;
  logic [NODE_W-1:0]  k;        // current node; also clear / build counter
  logic [LVL_W-1:0]   d;        // level of k
  logic [OP_W-1:0]    op;
  logic [RANGE_W-1:0] a, b;
  logic [DATA_W-1:0]  x;
  logic [DATA_W-1:0]  e;        // addend being pushed to children
  logic [DATA_W-1:0]  rv;       // value returned by the finished node
  logic               term;     // node was disjoint or covered
  logic [DATA_W-1:0]  tmp;      // left child sum during build
  logic [DATA_W-1:0]  res;
  logic [DATA_W-1:0]  acc [0:LOG-1];  // left-subtree result per level

  // node RAM ports
  logic              sum_we, pend_we;
  logic [NODE_W-1:0] sum_wa, pend_wa, sum_ra, pend_ra;
  logic [DATA_W-1:0] sum_wd, pend_wd, sum_q, pend_q;

  lst_ram #(.ADDR_W(NODE_W), .WIDTH(DATA_W)) u_sum (
    .clk(clk), .we(sum_we), .waddr(sum_wa), .wdata(sum_wd),
    .raddr(sum_ra), .rdata(sum_q)
  );

  lst_ram #(.ADDR_W(NODE_W), .WIDTH(DATA_W)) u_pend (
    .clk(clk), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
    .raddr(pend_ra), .rdata(pend_q)
  );

  // Segment [l, r) of node k at level d.
  logic [LVL_W-1:0]  sh;
  logic [NODE_W:0]   ksh, l_pos, len, r_pos;
  logic              disjoint, covered, internal;
  logic [DATA_W-1:0] e_eff, ns, total;
  logic [LVL_W-1:0]  dm1;

  always_comb begin
    sh       = LVL_W'(LOG) - d;
    ksh      = {1'b0, k} << sh;
    l_pos    = ksh - (NODE_W+1)'(T_NODE);
    len      = (NODE_W+1)'(1) << sh;
    r_pos    = l_pos + len;
    disjoint = (r_pos <= {1'b0, a}) || ({1'b0, b} <= l_pos);
    covered  = ({1'b0, a} <= l_pos) && (r_pos <= {1'b0, b});
    internal = !k[NODE_W-1];
    // covered add folds into the push: children get p+x, sum gets (p+x)*len
    e_eff    = pend_q + (((op == OP_ADD) && covered) ? x : '0);
    ns       = sum_q + (e_eff << sh);
    dm1      = d - LVL_W'(1);
    total    = acc[dm1] + rv;
  end

  // RAM port selection
  always_comb begin
    sum_we  = 1'b0;
    sum_wa  = k;
    sum_wd  = '0;
    pend_we = 1'b0;
    pend_wa = k;
    pend_wd = '0;
    sum_ra  = k;
    pend_ra = k;
    case (state)
      S_CLR: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
      end
      S_SET: begin
        sum_we = !a[RANGE_W-1];
        sum_wa = {1'b1, a[LOG-1:0]};
        sum_wd = x;
      end
      S_BR0: sum_ra = {k[NODE_W-2:0], 1'b0};
      S_BR1: sum_ra = {k[NODE_W-2:0], 1'b1};
      S_BW: begin
        sum_we = 1'b1;
        sum_wd = tmp + sum_q;
      end
      S_VEX: begin
        sum_we  = 1'b1;
        sum_wd  = ns;
        pend_we = 1'b1;
        pend_ra = {k[NODE_W-2:0], 1'b0};
      end
      S_C0W: begin
        pend_we = 1'b1;
        pend_wa = {k[NODE_W-2:0], 1'b0};
        pend_wd = pend_q + e;
        pend_ra = {k[NODE_W-2:0], 1'b1};
      end
      S_C1W: begin
        pend_we = 1'b1;
        pend_wa = {k[NODE_W-2:0], 1'b1};
        pend_wd = pend_q + e;
      end
      S_RET: begin
        sum_we = (k != NODE_W'(1)) && k[0] && (op == OP_ADD);
        sum_wa = k >> 1;
        sum_wd = total;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      k     <= '0;
    end else begin
      case (state)
        S_CLR: begin
          k <= k + NODE_W'(1);
          if (&k) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op  <= s_axis_tdata[1:0];
            a   <= s_axis_tdata[12:2];
            b   <= s_axis_tdata[23:13];
            x   <= s_axis_tdata[87:24];
            res <= '0;
            case (s_axis_tdata[1:0])
              OP_SET: state <= S_SET;
              OP_BUILD: begin
                k     <= T_NODE - NODE_W'(1);
                state <= S_BR0;
              end
              default: begin
                k     <= NODE_W'(1);
                d     <= '0;
                state <= S_VRD;
              end
            endcase
          end
        end
        S_SET: state <= S_OUT;
        S_BR0: state <= S_BR1;
        S_BR1: begin
          tmp   <= sum_q;
          state <= S_BW;
        end
        S_BW: begin
          k     <= k - NODE_W'(1);
          state <= (k == NODE_W'(1)) ? S_OUT : S_BR0;
        end
        S_VRD: state <= S_VEX;
        S_VEX: begin
          e    <= e_eff;
          term <= disjoint || covered;
          rv   <= ((op == OP_QUERY) && disjoint) ? '0 : ns;
          if (internal && (e_eff != '0)) begin
            state <= S_C0W;
          end else if (disjoint || covered) begin
            state <= S_RET;
          end else begin
            k     <= {k[NODE_W-2:0], 1'b0};
            d     <= d + LVL_W'(1);
            state <= S_VRD;
          end
        end
        S_C0W: state <= S_C1W;
        S_C1W: begin
          if (term) begin
            state <= S_RET;
          end else begin
            k     <= {k[NODE_W-2:0], 1'b0};
            d     <= d + LVL_W'(1);
            state <= S_VRD;
          end
        end
        S_RET: begin
          if (k == NODE_W'(1)) begin
            res   <= rv;
            state <= S_OUT;
          end else if (!k[0]) begin
            acc[dm1] <= rv;
            k        <= k + NODE_W'(1);
            state    <= S_VRD;
          end else begin
            rv <= total;
            k  <= k >> 1;
            d  <= dm1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = res;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lazy segment tree: a predictor keeps its own
// node sums and pending adds, every transfer on the output is checked.
// ----------------------------------------------------------------------------
module testbench;
  import lst_pkg::*;

  localparam int TREE      = 1 << LOG;
  localparam int WDOG_LIM  = 60000;    // covers the clearing pass and a build

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;

  always #6 clk = ~clk;

  lazy_segment_tree_range_add_sum DUT (.*);

  // predictor state
  logic [DATA_W-1:0] tree_sum [2*TREE];
  logic [DATA_W-1:0] tree_pend[2*TREE];

  logic [IN_W-1:0]   item_q[$];
  logic [DATA_W-1:0] sum_q[$];
  int idle_pct = 0, stall_pct = 0;
  int errors = 0, mismatches = 0, n_sent = 0, n_seen = 0, wdog = 0;
  bit hold_send = 0;

  function automatic void enqueue(logic [IN_W-1:0] v);
    item_q = {item_q, v};
  endfunction

  function automatic void settle(int k, int len);
    logic [DATA_W-1:0] p;
    p = tree_pend[k];
    if (p != 0) begin
      if (k < TREE) begin
        tree_pend[2*k]   += p;
        tree_pend[2*k+1] += p;
      end
      tree_sum[k] += p * DATA_W'(len);
      tree_pend[k] = '0;
    end
  endfunction

  function automatic logic [DATA_W-1:0] add_range(int a, int b, logic [DATA_W-1:0] x,
                                                  int k, int l, int r);
    int m;
    settle(k, r - l);
    if (r <= a || b <= l) return tree_sum[k];
    if (a <= l && r <= b) begin
      tree_pend[k] += x;
      settle(k, r - l);
      return tree_sum[k];
    end
    m = (l + r) >> 1;
    tree_sum[k] = add_range(a, b, x, 2*k, l, m) + add_range(a, b, x, 2*k+1, m, r);
    return tree_sum[k];
  endfunction

  function automatic logic [DATA_W-1:0] sum_range(int a, int b, int k, int l, int r);
    int m;
    settle(k, r - l);
    if (r <= a || b <= l) return '0;
    if (a <= l && r <= b) return tree_sum[k];
    m = (l + r) >> 1;
    return sum_range(a, b, 2*k, l, m) + sum_range(a, b, 2*k+1, m, r);
  endfunction

  // Expected sum for one accepted transfer
  function automatic logic [DATA_W-1:0] predict_sum(logic [IN_W-1:0] d);
    logic [OP_W-1:0]    op;
    int                 lo, hi;
    logic [DATA_W-1:0]  val;
    op  = d[1:0];
    lo  = int'(d[12:2]);
    hi  = int'(d[23:13]);
    val = d[87:24];
    case (op)
      OP_SET: begin
        if (lo < TREE) tree_sum[TREE + lo] = val;
        return '0;
      end
      OP_BUILD: begin
        for (int k = TREE - 1; k > 0; k--) tree_sum[k] = tree_sum[2*k] + tree_sum[2*k+1];
        return '0;
      end
      OP_ADD:  return add_range(lo, hi, val, 1, 0, TREE);
      default: return sum_range(lo, hi, 1, 0, TREE);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack(logic [OP_W-1:0] op, int lo, int hi,
                                           logic [DATA_W-1:0] v);
    return {v, RANGE_W'(hi), RANGE_W'(lo), op};
  endfunction

  function automatic logic [DATA_W-1:0] rand_val();
    case ($urandom_range(0, 4))
      0:       return {$urandom, $urandom};
      1:       return DATA_W'($signed($urandom_range(0, 200)) - 100);
      2:       return {1'b0, {63{1'b1}}};
      3:       return {1'b1, 63'd0};
      default: return DATA_W'($urandom_range(0, 100000));
    endcase
  endfunction

  // Random range: mostly small spans, some wide, some empty or past the end
  task automatic rand_bounds(output int lo, output int hi);
    lo = $urandom_range(0, 2047);
    case ($urandom_range(0, 5))
      0:       begin lo = $urandom_range(0, 1023); hi = $urandom_range(lo, 1024); end
      1:       begin lo = $urandom_range(0, 1023); hi = lo + $urandom_range(1, 16); end
      2:       hi = $urandom_range(0, 2047);
      3:       begin lo = $urandom_range(0, 1024); hi = $urandom_range(0, lo); end
      default: begin lo = $urandom_range(0, 1023); hi = lo + $urandom_range(1, 200); end
    endcase
  endtask

  // Driver: one transfer in flight on s_axis at a time
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        sum_q = {sum_q, predict_sum(s_axis_tdata)};
        n_sent++;
      end
      if (item_q.size() > 0 && !hold_send && $urandom_range(0, 99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and output stall
  always @(posedge clk) begin
    logic [DATA_W-1:0] exp_sum;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_seen++;
        if (sum_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result sum=%h", m_axis_tdata);
        end else begin
          exp_sum = sum_q.pop_front();
          if (exp_sum !== m_axis_tdata) begin
            errors++;
            if (mismatches++ < 10)
              $display("sum mismatch: expected %h got %h", exp_sum, m_axis_tdata);
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) wdog <= 0;
    else if (!rst) wdog <= wdog + 1;
    if (wdog >= WDOG_LIM) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (item_q.size() > 0 || s_axis_tvalid || sum_q.size() > 0) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int lo, hi;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0:       enqueue(pack(OP_BUILD, $urandom_range(0, 2047),
                               $urandom_range(0, 2047), rand_val()));
        1, 2, 3: enqueue(pack(OP_SET, $urandom_range(0, 2047),
                               $urandom_range(0, 2047), rand_val()));
        4, 5, 6, 7, 8, 9, 10, 11: begin
          rand_bounds(lo, hi);
          enqueue(pack(OP_ADD, lo, hi, rand_val()));
        end
        default: begin
          rand_bounds(lo, hi);
          enqueue(pack(OP_QUERY, lo, hi, {$urandom, $urandom}));
        end
      endcase
    end
  endtask

  initial begin
    for (int k = 0; k < 2*TREE; k++) begin
      tree_sum[k]  = '0;
      tree_pend[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every operation, empty/reversed and overlong ranges
    enqueue(pack(OP_QUERY, 0, 1024, '0));
    enqueue(pack(OP_SET, 0, 0, {1'b0, {63{1'b1}}}));
    enqueue(pack(OP_SET, 1023, 2047, {1'b1, 63'd0}));
    enqueue(pack(OP_SET, 2047, 0, '1));             // beyond the tree, ignored
    enqueue(pack(OP_SET, 1024, 0, 64'd5));          // beyond the tree, ignored
    enqueue(pack(OP_QUERY, 0, 1024, '0));           // internal sums still stale
    enqueue(pack(OP_BUILD, 2047, 2047, '1));
    enqueue(pack(OP_QUERY, 0, 1024, '0));
    enqueue(pack(OP_ADD, 0, 1024, 64'd3));
    enqueue(pack(OP_ADD, 5, 5, 64'd7));             // empty range
    enqueue(pack(OP_ADD, 700, 10, '1));             // reversed range
    enqueue(pack(OP_QUERY, 9, 3, '0));
    enqueue(pack(OP_ADD, 1000, 2047, {1'b1, 63'd0}));
    enqueue(pack(OP_QUERY, 1020, 2047, '0));
    enqueue(pack(OP_ADD, 1, 2, {1'b0, {63{1'b1}}}));
    enqueue(pack(OP_SET, 512, 0, 64'd11));          // pending add above stays
    enqueue(pack(OP_BUILD, 0, 0, '0));
    enqueue(pack(OP_QUERY, 511, 513, '0));
    enqueue(pack(OP_QUERY, 0, 2047, '0));
    enqueue(pack(OP_QUERY, 1023, 1024, '0));
    drain();

    // Random phases with different idle and stall mixes
    idle_pct = 0;  stall_pct = 0;  random_phase(200); drain();
    idle_pct = 64; stall_pct = 0;  random_phase(200);
    // let some items go out, then pause the sender until all results are back
    repeat (400) @(posedge clk);
    hold_send = 1; while (sum_q.size() > 0 || s_axis_tvalid) @(posedge clk);
    hold_send = 0; drain();
    idle_pct = 0;  stall_pct = 64; random_phase(200); drain();
    idle_pct = 35; stall_pct = 35; random_phase(200); drain();
    repeat (200) @(posedge clk);

    $display("Covered %0d operations (set, build, range add, range sum), %0d results,",
             n_sent, n_seen);
    $display("under four sender-idle / receiver-stall mixes.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
